// ===== rtl/pulse_width_bit_receiver_macros.svh =====
// ----------------------------------------------------------------------------
// pulse_width_bit_receiver_macros
// Assertion helpers used by the receiver top level.
// ----------------------------------------------------------------------------
`ifndef PULSE_WIDTH_BIT_RECEIVER_MACROS_SVH
`define PULSE_WIDTH_BIT_RECEIVER_MACROS_SVH

// same-cycle implication, checked out of reset
`define PWBR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pwbr assertion failed");

// next-cycle implication, checked out of reset
`define PWBR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pwbr assertion failed");

`endif

// ===== rtl/pwbr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwbr_pkg
// Shared types and constants of the pulse-width bit receiver.
// ----------------------------------------------------------------------------
package pwbr_pkg;

	localparam int unsigned AddrW = 3;
	localparam int unsigned DataW = 32;

	// register index (byte address / 4)
	localparam logic REG_TIMEOUT = 1'b0;

	localparam logic [7:0] LIMIT_RESET = 8'd40;
	localparam logic [7:0] LIMIT_MIN   = 8'd2;
	localparam logic [2:0] LAST_BIT    = 3'd7;
	localparam logic [7:0] COUNT_MAX   = 8'd255;

	typedef logic [1:0] status_t;
	localparam status_t ST_BYTE    = 2'd0;
	localparam status_t ST_STOP    = 2'd1;
	localparam status_t ST_TIMEOUT = 2'd2;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_START = 4'b0010,
		PH_LOW   = 4'b0100,
		PH_HIGH  = 4'b1000
	} phase_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] data_byte;
		logic [7:0] byte_total;
	} result_t;

endpackage

// ===== rtl/pwbr_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwbr_regs
// APB register file holding the timeout limit.
// ----------------------------------------------------------------------------
module pwbr_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pwbr_pkg::AddrW-1:0] paddr,
	input  logic [pwbr_pkg::DataW-1:0] pwdata,
	output logic [pwbr_pkg::DataW-1:0] prdata,
	output logic [7:0]                 timeout_limit
);
	import pwbr_pkg::*;

	logic [7:0] limit_q;
	logic       wr_en;

	assign wr_en = psel && penable && pwrite && (paddr[AddrW-1] == REG_TIMEOUT);

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (wr_en) begin
			limit_q <= pwdata[7:0];
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		if (paddr[AddrW-1] == REG_TIMEOUT) begin
			prdata = {{(DataW-8){1'b0}}, limit_q};
		end
	end

	assign timeout_limit = limit_q;

endmodule

// ===== rtl/pwbr_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwbr_core
// Frame state and per-sample decode: phase counters, bit shifter, byte count.
// ----------------------------------------------------------------------------
module pwbr_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              cmd,
	input  logic              level,
	input  logic [7:0]        timeout_limit,
	output logic              res_valid,
	output pwbr_pkg::result_t res
);
	import pwbr_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] low_q, low_d;
	logic [7:0] high_q, high_d;
	logic [7:0] shift_q, shift_d;
	logic [2:0] bitpos_q, bitpos_d;
	logic [7:0] bytes_q, bytes_d;
	logic [7:0] lim;
	logic [7:0] low_inc;
	logic [7:0] high_inc;
	logic [7:0] shifted;
	logic       bit_val;

	// limits below two act as two
	assign lim      = (timeout_limit < LIMIT_MIN) ? LIMIT_MIN : timeout_limit;
	assign low_inc  = 8'(low_q + 8'd1);
	assign high_inc = 8'(high_q + 8'd1);
	assign bit_val  = (low_q < high_q);
	assign shifted  = {shift_q[6:0], bit_val};

	// next state and result
	always_comb begin
		phase_d   = phase_q;
		low_d     = low_q;
		high_d    = high_q;
		shift_d   = shift_q;
		bitpos_d  = bitpos_q;
		bytes_d   = bytes_q;
		res_valid = 1'b0;
		res       = '0;
		if (cmd) begin
			phase_d  = PH_START;
			low_d    = '0;
			high_d   = '0;
			shift_d  = '0;
			bitpos_d = '0;
			bytes_d  = '0;
		end else begin
			case (phase_q)
				PH_START: begin
					if (level) begin
						high_d = high_inc;
						if (high_inc >= lim) begin
							phase_d    = PH_IDLE;
							res_valid  = 1'b1;
							res.status = ST_TIMEOUT;
						end
					end else begin
						phase_d = PH_LOW;
						low_d   = 8'd1;
						high_d  = '0;
					end
				end
				PH_LOW: begin
					if (!level) begin
						low_d = low_inc;
						if (low_inc >= lim) begin
							phase_d    = PH_IDLE;
							res_valid  = 1'b1;
							res.status = ST_TIMEOUT;
						end
					end else begin
						phase_d = PH_HIGH;
						high_d  = 8'd1;
					end
				end
				PH_HIGH: begin
					if (level) begin
						high_d = high_inc;
						if (high_inc >= lim) begin
							phase_d        = PH_IDLE;
							res_valid      = 1'b1;
							res.status     = ST_STOP;
							res.byte_total = bytes_q;
						end
					end else begin
						// falling edge closes the bit
						phase_d = PH_LOW;
						low_d   = 8'd1;
						high_d  = '0;
						if (bitpos_q == LAST_BIT) begin
							bitpos_d      = '0;
							shift_d       = '0;
							bytes_d       = (bytes_q == COUNT_MAX) ? bytes_q : 8'(bytes_q + 8'd1);
							res_valid     = 1'b1;
							res.status    = ST_BYTE;
							res.data_byte = shifted;
						end else begin
							shift_d  = shifted;
							bitpos_d = 3'(bitpos_q + 3'd1);
						end
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	// phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (step) begin
			phase_q <= phase_d;
		end
	end

	// frame counters and shifter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q    <= '0;
			high_q   <= '0;
			shift_q  <= '0;
			bitpos_q <= '0;
			bytes_q  <= '0;
		end else if (step) begin
			low_q    <= low_d;
			high_q   <= high_d;
			shift_q  <= shift_d;
			bitpos_q <= bitpos_d;
			bytes_q  <= bytes_d;
		end
	end

endmodule

// ===== rtl/pwbr_outreg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwbr_outreg
// Result register holding one word until the receiver takes it.
// ----------------------------------------------------------------------------
module pwbr_outreg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  pwbr_pkg::result_t res,
	input  logic              out_ready,
	output logic              out_valid,
	output pwbr_pkg::status_t status,
	output logic [7:0]        data_byte,
	output logic [7:0]        byte_total
);
	import pwbr_pkg::*;

	logic    valid_q;
	result_t res_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid  = valid_q;
	assign status     = res_q.status;
	assign data_byte  = res_q.data_byte;
	assign byte_total = res_q.byte_total;

endmodule

// ===== rtl/pulse_width_bit_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_width_bit_receiver
// Single-wire pulse-width decoder: line samples in, bytes and frame status out.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one word per sampling tick, either an arm
// command or a line sample. Output channel (out_valid/out_ready): a data byte,
// a frame end with the byte total, or a timeout.
// A word is registered in the input stage at acceptance, decoded against the
// frame state once the output side is free, and its result (if any) is then
// registered in the result register. One word per cycle is taken while the
// output side is free or draining, set by the single decode stage between
// the input and result registers.
// When the receiver stalls with a result held, the input stage holds one more
// word and in_ready drops until the result is taken.
// Reset empties both stages, idles the frame logic (it waits for an arm
// command) and sets the timeout limit to 40 samples.
// The APB port holds the timeout limit at address 0; pready is tied high.
// ----------------------------------------------------------------------------
module pulse_width_bit_receiver (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       command,
	input  logic                       line_level,
	output logic                       out_valid,
	input  logic                       out_ready,
	output pwbr_pkg::status_t          status,
	output logic [7:0]                 data_byte,
	output logic [7:0]                 byte_total,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pwbr_pkg::AddrW-1:0] paddr,
	input  logic [pwbr_pkg::DataW-1:0] pwdata,
	output logic [pwbr_pkg::DataW-1:0] prdata,
	output logic                       pready
);
	import pwbr_pkg::*;
	`include "pulse_width_bit_receiver_macros.svh"

	logic       valid_s1;
	logic       cmd_s1;
	logic       level_s1;
	logic       out_free;
	logic       step;
	logic       res_valid;
	logic       res_load;
	result_t    res;
	logic [7:0] timeout_limit;

	assign pready   = 1'b1;
	assign out_free = !out_valid || out_ready;
	assign step     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;
	assign res_load = step && res_valid;

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input stage word
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1   <= command;
			level_s1 <= line_level;
		end
	end

	pwbr_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.timeout_limit (timeout_limit)
	);

	pwbr_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.cmd           (cmd_s1),
		.level         (level_s1),
		.timeout_limit (timeout_limit),
		.res_valid     (res_valid),
		.res           (res)
	);

	pwbr_outreg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (res_load),
		.res        (res),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.status     (status),
		.data_byte  (data_byte),
		.byte_total (byte_total)
	);

	// assertions
	`PWBR_ASSERT_NEXT(a_s1_holds, valid_s1 && !out_free, valid_s1 && $stable(cmd_s1) && $stable(level_s1))
	`PWBR_ASSERT_NOW(a_arm_silent, step && cmd_s1, !res_load)
	`PWBR_ASSERT_NOW(a_total_only_stop, out_valid && (status != ST_STOP), byte_total == 8'd0)

endmodule
